// ===== design/metr_pkg.sv =====
// ----------------------------------------------------------------------------
// metr_pkg
// Shared types and constants of the metatile background renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package metr_pkg;

    // command codes of an input item
    typedef enum logic [2:0] {
        CMD_RENDER  = 3'd0,
        CMD_WORLD   = 3'd1,
        CMD_ATTR    = 3'd2,
        CMD_BLOCK   = 3'd3,
        CMD_CHR     = 3'd4,
        CMD_PALETTE = 3'd5
    } t_cmd;

    // configuration register indexes
    localparam logic [1:0] REG_SCROLL_H = 2'd0;
    localparam logic [1:0] REG_SCROLL_V = 2'd1;
    localparam logic [1:0] REG_WIDTH    = 2'd2;
    localparam logic [1:0] REG_HEIGHT   = 2'd3;

    localparam int ADDR_W       = 14;
    localparam int DATA_W       = 35;
    localparam int WADDR_MAX_W  = 16;
    localparam int SCR_MAX_W    = 8;
    localparam int QUEUE_DEPTH  = 8;
    localparam int OUT_DEPTH    = 8;
    localparam int CNT_W        = 4;

    localparam logic [5:0] ATTR_RESET  = 6'h04;
    localparam int         DEF_VALID   = 34;

    typedef struct packed {
        logic [10:0] scroll_h;
        logic [10:0] scroll_v;
        logic [3:0]  width_screens;
        logic [3:0]  height_screens;
    } t_cfg;

    // one classified item between front and back
    typedef struct packed {
        t_cmd                   cmd;
        logic                   in_world;
        logic [WADDR_MAX_W-1:0] world_addr;
        logic [SCR_MAX_W-1:0]   scr;
        logic [1:0]             slot;
        logic [2:0]             row;
        logic [2:0]             col;
        logic [ADDR_W-1:0]      waddr;
        logic [DATA_W-1:0]      wdata;
    } t_job;

    typedef struct packed {
        logic busy;
        logic clearing;
    } t_back_stat;

    typedef struct packed {
        logic [5:0] color_index;
        logic       drawn;
    } t_pix;

endpackage

`default_nettype wire

// ===== design/metr_ifs.sv =====
// ----------------------------------------------------------------------------
// metr_ifs
// Valid/ready channels of the renderer: command items in, pixel items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface metr_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  view_x;
    logic [7:0]  view_y;
    logic [13:0] address;
    logic [34:0] data;

    modport source (output valid, command, view_x, view_y, address, data, input ready);
    modport sink   (input valid, command, view_x, view_y, address, data, output ready);
endinterface

interface metr_pix_if;
    logic       valid;
    logic       ready;
    logic [5:0] color_index;
    logic       drawn;

    modport source (output valid, color_index, drawn, input ready);
    modport sink   (input valid, color_index, drawn, output ready);
endinterface

`default_nettype wire

// ===== design/metr_fifo.sv =====
// ----------------------------------------------------------------------------
// metr_fifo
// Small register FIFO with occupancy count, used for the job queue and the
// pixel output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module metr_fifo
    import metr_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DW-1:0]     i_data,
    input  wire logic              i_pop,
    output logic [DW-1:0]          o_data,
    output logic                   o_valid,
    output logic [CNT_W-1:0]       o_count
);
    localparam int PW = $clog2(DEPTH);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== design/metr_front.sv =====
// ----------------------------------------------------------------------------
// metr_front
// Accepts command items, maps view pixels to world addresses and folds
// write addresses into table range, then hands jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module metr_front
    import metr_pkg::*;
#(
    parameter int MAX_SCREENS_W    = 8,
    parameter int MAX_SCREENS_H    = 8,
    parameter int NUM_BLOCKS       = 256,
    parameter int NUM_CHR_SETS     = 4,
    parameter int NUM_PALETTE_SETS = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    metr_cmd_if.sink              i_cmd_ch,
    input  wire t_cfg             i_cfg,
    input  wire t_back_stat       i_stat,
    input  wire logic [CNT_W-1:0] i_queue_count,
    output logic                  o_push,
    output t_job                  o_job
);
    // table depths and their reciprocals for the address fold
    localparam int D_WORLD = MAX_SCREENS_W * MAX_SCREENS_H * 256;
    localparam int D_ATTR  = MAX_SCREENS_W * MAX_SCREENS_H;
    localparam int D_BLOCK = NUM_BLOCKS;
    localparam int D_CHR   = NUM_CHR_SETS * 2048;
    localparam int D_PAL   = NUM_PALETTE_SETS * 16;
    localparam int S_WORLD = ADDR_W + $clog2(D_WORLD);
    localparam int S_ATTR  = ADDR_W + $clog2(D_ATTR);
    localparam int S_BLOCK = ADDR_W + $clog2(D_BLOCK);
    localparam int S_CHR   = ADDR_W + $clog2(D_CHR);
    localparam int S_PAL   = ADDR_W + $clog2(D_PAL);
    localparam int M_WORLD = ((2 ** S_WORLD) + D_WORLD - 1) / D_WORLD;
    localparam int M_ATTR  = ((2 ** S_ATTR) + D_ATTR - 1) / D_ATTR;
    localparam int M_BLOCK = ((2 ** S_BLOCK) + D_BLOCK - 1) / D_BLOCK;
    localparam int M_CHR   = ((2 ** S_CHR) + D_CHR - 1) / D_CHR;
    localparam int M_PAL   = ((2 ** S_PAL) + D_PAL - 1) / D_PAL;

    logic        accept;
    logic [11:0] wx;
    logic [11:0] wy;
    logic [4:0]  wlim;
    logic [4:0]  hlim;
    logic [15:0] m_sel;
    logic [4:0]  s_sel;
    logic [29:0] prod;
    logic [16:0] d_sel;
    logic [30:0] back_prod;
    logic [2:0]  n_pending;
    logic [CNT_W:0] used;

    // stage 1
    logic              r_f1_v;
    t_cmd              r_f1_cmd;
    logic [ADDR_W-1:0] r_f1_addr;
    logic [DATA_W-1:0] r_f1_data;
    logic [7:0]        r_f1_ix;
    logic [7:0]        r_f1_iy;
    logic [3:0]        r_f1_sx;
    logic [3:0]        r_f1_sy;
    logic              r_f1_inside;
    logic [ADDR_W-1:0] r_f1_q;
    // stage 2
    logic              r_f2_v;
    t_job              r_f2_job;
    t_job              n_job;

    assign n_pending = 3'(r_f1_v) + 3'(r_f2_v);
    assign used      = (CNT_W+1)'(i_queue_count) + (CNT_W+1)'(n_pending);
    assign i_cmd_ch.ready = !i_stat.busy && (used < (CNT_W+1)'(QUEUE_DEPTH));
    assign accept = i_cmd_ch.valid && i_cmd_ch.ready;

    always_comb begin
        wx   = 12'(i_cmd_ch.view_x) + 12'(i_cfg.scroll_h);
        wy   = 12'(i_cmd_ch.view_y) + 12'(i_cfg.scroll_v);
        wlim = (5'(i_cfg.width_screens) > 5'(MAX_SCREENS_W)) ? 5'(MAX_SCREENS_W)
                                                              : 5'(i_cfg.width_screens);
        hlim = (5'(i_cfg.height_screens) > 5'(MAX_SCREENS_H)) ? 5'(MAX_SCREENS_H)
                                                               : 5'(i_cfg.height_screens);
    end

    always_comb begin
        case (t_cmd'(i_cmd_ch.command))
            CMD_WORLD:   begin m_sel = 16'(M_WORLD); s_sel = 5'(S_WORLD); end
            CMD_ATTR:    begin m_sel = 16'(M_ATTR);  s_sel = 5'(S_ATTR);  end
            CMD_BLOCK:   begin m_sel = 16'(M_BLOCK); s_sel = 5'(S_BLOCK); end
            CMD_CHR:     begin m_sel = 16'(M_CHR);   s_sel = 5'(S_CHR);   end
            CMD_PALETTE: begin m_sel = 16'(M_PAL);   s_sel = 5'(S_PAL);   end
            default:     begin m_sel = '0;           s_sel = '0;          end
        endcase
        prod = 30'(i_cmd_ch.address) * 30'(m_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else begin
            // unknown commands are dropped here
            r_f1_v <= accept && (i_cmd_ch.command <= 3'(CMD_PALETTE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_cmd    <= t_cmd'(i_cmd_ch.command);
            r_f1_addr   <= i_cmd_ch.address;
            r_f1_data   <= i_cmd_ch.data;
            r_f1_ix     <= wx[7:0];
            r_f1_iy     <= wy[7:0];
            r_f1_sx     <= wx[11:8];
            r_f1_sy     <= wy[11:8];
            r_f1_inside <= (5'(wx[11:8]) < wlim) && (5'(wy[11:8]) < hlim);
            r_f1_q      <= ADDR_W'(prod >> s_sel);
        end
    end

    always_comb begin
        case (r_f1_cmd)
            CMD_WORLD:   d_sel = 17'(D_WORLD);
            CMD_ATTR:    d_sel = 17'(D_ATTR);
            CMD_BLOCK:   d_sel = 17'(D_BLOCK);
            CMD_CHR:     d_sel = 17'(D_CHR);
            CMD_PALETTE: d_sel = 17'(D_PAL);
            default:     d_sel = '0;
        endcase
        back_prod = 31'(r_f1_q) * 31'(d_sel);

        n_job            = '0;
        n_job.cmd        = r_f1_cmd;
        n_job.in_world   = r_f1_inside;
        n_job.scr        = 8'((8'(r_f1_sy) * 8'(MAX_SCREENS_W)) + 8'(r_f1_sx));
        n_job.world_addr = {n_job.scr, r_f1_iy[7:4], r_f1_ix[7:4]};
        n_job.slot       = {r_f1_iy[3], r_f1_ix[3]};
        n_job.row        = r_f1_iy[2:0];
        n_job.col        = r_f1_ix[2:0];
        n_job.waddr      = r_f1_addr - back_prod[ADDR_W-1:0];
        n_job.wdata      = r_f1_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_v) begin
            r_f2_job <= n_job;
        end
    end

    assign o_push = r_f2_v;
    assign o_job  = r_f2_job;

endmodule

`default_nettype wire

// ===== design/metr_back.sv =====
// ----------------------------------------------------------------------------
// metr_back
// Owns the tables. Executes writes and runs renders through a four stage
// chain of table reads: world block, block definition, chr rows, palette.
// ----------------------------------------------------------------------------
`default_nettype none

module metr_back
    import metr_pkg::*;
#(
    parameter int MAX_SCREENS_W    = 8,
    parameter int MAX_SCREENS_H    = 8,
    parameter int NUM_BLOCKS       = 256,
    parameter int NUM_CHR_SETS     = 4,
    parameter int NUM_PALETTE_SETS = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    input  wire t_job             i_job,
    output logic                  o_job_pop,
    input  wire logic [CNT_W-1:0] i_out_count,
    output logic                  o_push,
    output t_pix                  o_pix,
    output t_back_stat            o_stat
);
    localparam int WDEPTH = MAX_SCREENS_W * MAX_SCREENS_H * 256;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int SDEPTH = MAX_SCREENS_W * MAX_SCREENS_H;
    localparam int SCW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int BKW    = $clog2(NUM_BLOCKS);
    localparam int CDEPTH = NUM_CHR_SETS * 2048;
    localparam int CHW    = $clog2(CDEPTH);
    localparam int PDEPTH = NUM_PALETTE_SETS * 16;
    localparam int PLW    = $clog2(PDEPTH);

    logic [7:0]        r_world [WDEPTH];
    logic [5:0]        r_attr  [SDEPTH];
    logic [DATA_W-1:0] r_blk   [NUM_BLOCKS];
    logic [7:0]        r_chr   [CDEPTH];
    logic [5:0]        r_pal   [PDEPTH];
    logic [SDEPTH-1:0]     r_attr_vld;
    logic [NUM_BLOCKS-1:0] r_blk_vld;

    logic           r_clearing;
    logic [WAW-1:0] r_clr;

    logic           deq;
    logic           is_render;
    logic           wr_hold;
    logic [2:0]     inflight;
    logic [CNT_W:0] used;
    logic           credit;

    // stage 1
    logic       r1_v, r1_ok;
    logic [1:0] r1_slot;
    logic [2:0] r1_row, r1_col;
    logic [7:0] r_bid;
    logic [5:0] r_attr_q;
    logic       r_attr_hit;
    // stage 2
    logic              r2_v, r2_ok;
    logic [1:0]        r2_slot;
    logic [2:0]        r2_row, r2_col;
    logic [5:0]        r2_attr;
    logic [DATA_W-1:0] r_def_q;
    logic              r_def_hit;
    // stage 3
    logic       r3_v, r3_ok;
    logic [2:0] r3_col;
    logic [1:0] r3_bpal, r3_pset;
    logic [7:0] r_chr_lo, r_chr_hi;
    // stage 4
    logic       r4_v, r4_ok;
    logic [5:0] r_pal_q;

    logic              n_ok2;
    logic [5:0]        attr1;
    logic [DATA_W-1:0] def2;
    logic              n_ok3;
    logic [7:0]        tile;
    logic [1:0]        cset;
    logic [CHW-1:0]    chr_lo_idx, chr_hi_idx;
    logic [1:0]        pix_c;
    logic [PLW-1:0]    pal_idx;

    assign is_render = (i_job.cmd == CMD_RENDER);
    // a chr or palette write waits until earlier renders have read that table
    assign wr_hold   = ((i_job.cmd == CMD_CHR) && r1_v)
                     || ((i_job.cmd == CMD_PALETTE) && (r1_v || r2_v));
    assign inflight  = 3'(r1_v) + 3'(r2_v) + 3'(r3_v) + 3'(r4_v);
    assign used      = (CNT_W+1)'(i_out_count) + (CNT_W+1)'(inflight);
    assign credit    = used < (CNT_W+1)'(OUT_DEPTH);
    assign deq       = i_job_valid && !r_clearing && (!is_render || credit) && !wr_hold;
    assign o_job_pop = deq;

    assign o_stat.busy     = r_clearing;
    assign o_stat.clearing = r_clearing;

    // world clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == WAW'(WDEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_world[r_clr] <= 8'h00;
        end else if (deq && i_job.cmd == CMD_WORLD) begin
            r_world[WAW'(i_job.waddr)] <= i_job.wdata[7:0];
        end
        r_bid <= r_world[WAW'(i_job.world_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (deq && i_job.cmd == CMD_ATTR) begin
            r_attr[SCW'(i_job.waddr)] <= i_job.wdata[5:0];
        end
        r_attr_q <= r_attr[SCW'(i_job.scr)];
    end

    always_ff @(posedge i_clk) begin
        if (deq && i_job.cmd == CMD_BLOCK) begin
            r_blk[BKW'(i_job.waddr)] <= i_job.wdata;
        end
        r_def_q <= r_blk[BKW'(r_bid)];
    end

    always_ff @(posedge i_clk) begin
        if (deq && i_job.cmd == CMD_CHR) begin
            r_chr[CHW'(i_job.waddr)] <= i_job.wdata[7:0];
        end
        r_chr_lo <= r_chr[chr_lo_idx];
        r_chr_hi <= r_chr[chr_hi_idx];
    end

    always_ff @(posedge i_clk) begin
        if (deq && i_job.cmd == CMD_PALETTE) begin
            r_pal[PLW'(i_job.waddr)] <= i_job.wdata[5:0];
        end
        r_pal_q <= r_pal[pal_idx];
    end

    // entry valid bits stand in for the reset values of attrs and defs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_vld <= '0;
            r_blk_vld  <= '0;
            r_attr_hit <= 1'b0;
            r_def_hit  <= 1'b0;
        end else begin
            if (deq && i_job.cmd == CMD_ATTR) begin
                r_attr_vld[SCW'(i_job.waddr)] <= 1'b1;
            end
            if (deq && i_job.cmd == CMD_BLOCK) begin
                r_blk_vld[BKW'(i_job.waddr)] <= 1'b1;
            end
            r_attr_hit <= r_attr_vld[SCW'(i_job.scr)];
            r_def_hit  <= r_blk_vld[BKW'(r_bid)];
        end
    end

    always_comb begin
        attr1 = r_attr_hit ? r_attr_q : ATTR_RESET;
        n_ok2 = r1_ok && (9'(r_bid) < 9'(NUM_BLOCKS));

        def2  = r_def_hit ? r_def_q : '0;
        n_ok3 = r2_ok && def2[DEF_VALID]
              && (5'(r2_attr[1:0]) < 5'(NUM_CHR_SETS))
              && (5'(r2_attr[3:2]) < 5'(NUM_CHR_SETS))
              && (5'(r2_attr[5:4]) < 5'(NUM_PALETTE_SETS));
        tile  = def2[{r2_slot, 3'b000} +: 8];
        // upper half of the tile numbers comes from the second chr set
        cset  = tile[7] ? r2_attr[3:2] : r2_attr[1:0];
        chr_lo_idx = CHW'({cset, tile[6:0], 1'b0, r2_row});
        chr_hi_idx = CHW'({cset, tile[6:0], 1'b1, r2_row});

        pix_c   = {r_chr_hi[3'd7 - r3_col], r_chr_lo[3'd7 - r3_col]};
        pal_idx = PLW'({r3_pset, r3_bpal, pix_c});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= deq && is_render;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ok   <= i_job.in_world;
        r1_slot <= i_job.slot;
        r1_row  <= i_job.row;
        r1_col  <= i_job.col;

        r2_ok   <= n_ok2;
        r2_slot <= r1_slot;
        r2_row  <= r1_row;
        r2_col  <= r1_col;
        r2_attr <= attr1;

        r3_ok   <= n_ok3;
        r3_col  <= r2_col;
        r3_bpal <= def2[33:32];
        r3_pset <= r2_attr[5:4];

        r4_ok   <= r3_ok;
    end

    assign o_push            = r4_v;
    assign o_pix.color_index = r4_ok ? r_pal_q : 6'h00;
    assign o_pix.drawn       = r4_ok;

    a_no_issue_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !deq)
        else $error("job taken during world clear");

    a_out_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= (CNT_W+1)'(OUT_DEPTH))
        else $error("renders in flight exceed output room");

    a_stage_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_v |-> $past(r2_v, 2))
        else $error("render stage valid out of sequence");

    a_drawn_needs_valid_def: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_v && !r2_ok) |=> !r3_ok)
        else $error("dropped render regained draw flag");

endmodule

`default_nettype wire

// ===== design/metatile_background_renderer.sv =====
// ----------------------------------------------------------------------------
// metatile_background_renderer
// Scrolled metatile tilemap renderer with table load commands.
// ----------------------------------------------------------------------------
// Takes one command item per clock while ready, which drops during the world
// clear and while the job queue is full. A render item returns one pixel item
// through two front stages, the job queue, four chained table reads and the
// output buffer; write items return nothing and update the tables in order
// with renders, and a chr or palette write waits until earlier renders have
// read that table. After reset the world block table is cleared one entry a
// cycle, all MAX_SCREENS_W * MAX_SCREENS_H * 256 entries (16384 by default),
// and no item is taken until that ends. The user must write configuration
// registers over the APB port only while idle; the block does not enforce it.
`default_nettype none

module metatile_background_renderer
    import metr_pkg::*;
#(
    parameter int MAX_SCREENS_W    = 8,
    parameter int MAX_SCREENS_H    = 8,
    parameter int NUM_BLOCKS       = 256,
    parameter int NUM_CHR_SETS     = 4,
    parameter int NUM_PALETTE_SETS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    metr_cmd_if.sink         i_cmd_ch,
    metr_pix_if.source       o_pix_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    t_cfg             r_cfg;
    t_back_stat       stat;
    logic             job_push;
    t_job             job_in;
    t_job             job_out;
    logic             job_valid;
    logic             job_pop;
    logic [CNT_W-1:0] queue_count;
    logic             pix_push;
    t_pix             pix_in;
    t_pix             pix_out;
    logic             pix_valid;
    logic             pix_pop;
    logic [CNT_W-1:0] out_count;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scroll_h       <= '0;
            r_cfg.scroll_v       <= '0;
            r_cfg.width_screens  <= 4'd1;
            r_cfg.height_screens <= 4'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SCROLL_H: r_cfg.scroll_h       <= pwdata[10:0];
                REG_SCROLL_V: r_cfg.scroll_v       <= pwdata[10:0];
                REG_WIDTH:    r_cfg.width_screens  <= pwdata[3:0];
                REG_HEIGHT:   r_cfg.height_screens <= pwdata[3:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SCROLL_H: prdata = 32'(r_cfg.scroll_h);
            REG_SCROLL_V: prdata = 32'(r_cfg.scroll_v);
            REG_WIDTH:    prdata = 32'(r_cfg.width_screens);
            REG_HEIGHT:   prdata = 32'(r_cfg.height_screens);
            default:      prdata = '0;
        endcase
    end

    metr_front #(
        .MAX_SCREENS_W    (MAX_SCREENS_W),
        .MAX_SCREENS_H    (MAX_SCREENS_H),
        .NUM_BLOCKS       (NUM_BLOCKS),
        .NUM_CHR_SETS     (NUM_CHR_SETS),
        .NUM_PALETTE_SETS (NUM_PALETTE_SETS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_ch      (i_cmd_ch),
        .i_cfg         (r_cfg),
        .i_stat        (stat),
        .i_queue_count (queue_count),
        .o_push        (job_push),
        .o_job         (job_in)
    );

    metr_fifo #(
        .DW    ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_valid (job_valid),
        .o_count (queue_count)
    );

    metr_back #(
        .MAX_SCREENS_W    (MAX_SCREENS_W),
        .MAX_SCREENS_H    (MAX_SCREENS_H),
        .NUM_BLOCKS       (NUM_BLOCKS),
        .NUM_CHR_SETS     (NUM_CHR_SETS),
        .NUM_PALETTE_SETS (NUM_PALETTE_SETS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_out_count (out_count),
        .o_push      (pix_push),
        .o_pix       (pix_in),
        .o_stat      (stat)
    );

    metr_fifo #(
        .DW    ($bits(t_pix)),
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pix_push),
        .i_data  (pix_in),
        .i_pop   (pix_pop),
        .o_data  (pix_out),
        .o_valid (pix_valid),
        .o_count (out_count)
    );

    assign pix_pop              = pix_valid && o_pix_ch.ready;
    assign o_pix_ch.valid       = pix_valid;
    assign o_pix_ch.color_index = pix_out.color_index;
    assign o_pix_ch.drawn       = pix_out.drawn;

endmodule

`default_nettype wire
